// ===== src/pipo_pkg.sv =====
// Shared types, constants and round functions for the PIPO-64/128 cipher pipeline.
`timescale 1ns / 1ps
package pipo_pkg;

  localparam int BLOCK_W     = 64;
  localparam int KEY_W       = 64;
  localparam int ROUNDS_DEF  = 13;
  localparam int ROUNDS_MAX  = 13;
  localparam int RND_W       = 4;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 64;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [RND_W-1:0]   rnd_t;

  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  // register index as seen in paddr[3]
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  localparam logic [2:0] ROT_AMT [7] = '{3'd2, 3'd1, 3'd5, 3'd6, 3'd3, 3'd4, 3'd7};

  function automatic logic [7:0] rotl8(input logic [7:0] x, input logic [2:0] n);
    logic [15:0] w;
    w = {x, x} << n;
    return w[15:8];
  endfunction

  function automatic key_t round_key(input rnd_t r, input key_t klo, input key_t khi);
    key_t k;
    k = r[0] ? klo : khi;
    k[63:56] = k[63:56] ^ {{(8-RND_W){1'b0}}, r};
    return k;
  endfunction

  function automatic block_t rot_fwd(input block_t x);
    block_t y;
    y = x;
    for (int b = 0; b < 7; b++) begin
      y[8*b +: 8] = rotl8(x[8*b +: 8], ROT_AMT[b]);
    end
    return y;
  endfunction

  function automatic block_t rot_inv(input block_t x);
    block_t y;
    y = x;
    for (int b = 0; b < 7; b++) begin
      y[8*b +: 8] = rotl8(x[8*b +: 8], 3'(4'd8 - {1'b0, ROT_AMT[b]}));
    end
    return y;
  endfunction

  function automatic block_t sbox_fwd(input block_t x);
    logic [7:0] s [8];
    logic [7:0] t0, t1, t2;
    block_t y;
    for (int b = 0; b < 8; b++) begin
      s[b] = x[8*b +: 8];
    end
    s[2] = s[2] ^ (s[0] & s[1]);
    s[3] = s[3] ^ (s[4] & s[2]);
    s[0] = s[0] ^ s[3];
    s[1] = s[1] ^ s[4];
    s[4] = s[4] ^ (s[3] | s[2]);
    s[2] = s[2] ^ s[0];
    s[3] = s[3] ^ (s[2] & s[1]);

    s[5] = s[5] ^ (s[6] & s[7]);
    s[7] = s[7] ^ (s[5] | s[6]);
    s[6] = s[6] ^ (s[5] | s[7]);
    s[5] = ~s[5];

    s[0] = s[0] ^ s[6];
    s[4] = s[4] ^ s[5];
    s[3] = s[3] ^ s[7];

    t0 = s[0]; t1 = s[4]; t2 = s[3];
    s[1] = s[1] ^ (t0 & s[2]);
    t0   = t0 ^ s[1];
    s[1] = s[1] ^ (t2 | t1);
    t1   = t1 ^ s[2];
    s[2] = s[2] ^ (s[1] | t2);
    t2   = t2 ^ (t1 & t0);

    s[5] = s[5] ^ t0;
    t0   = s[6] ^ t2;
    s[6] = s[7] ^ t1;
    s[7] = s[0];
    s[0] = t0;
    t1 = s[4]; s[4] = s[1]; s[1] = t1;
    t2 = s[3]; s[3] = s[2]; s[2] = t2;
    for (int b = 0; b < 8; b++) begin
      y[8*b +: 8] = s[b];
    end
    return y;
  endfunction

  function automatic block_t inv_sbox(input block_t x);
    logic [7:0] s [8];
    logic [7:0] t0, t1, t2;
    block_t y;
    for (int b = 0; b < 8; b++) begin
      s[b] = x[8*b +: 8];
    end
    t0 = s[0]; s[0] = s[7]; s[7] = s[6]; s[6] = t0;
    t0 = s[0]; t1 = s[1]; t2 = s[2];

    s[3] = s[3] ^ (s[4] | t2);
    s[4] = s[4] ^ (t2 | t1);
    t1   = t1 ^ s[3];
    t0   = t0 ^ s[4];
    t2   = t2 ^ (t1 & t0);
    s[4] = s[4] ^ (s[3] & s[0]);

    s[7] = s[7] ^ t1;
    s[6] = s[6] ^ t2;
    s[5] = s[5] ^ t0;
    t0 = s[4]; s[4] = s[1]; s[1] = t0;
    t0 = s[2]; s[2] = s[3]; s[3] = t0;

    s[0] = s[0] ^ s[6];
    s[4] = s[4] ^ s[5];
    s[3] = s[3] ^ s[7];

    s[3] = s[3] ^ (s[2] & s[1]);
    s[2] = s[2] ^ s[0];
    s[4] = s[4] ^ (s[3] | s[2]);
    s[1] = s[1] ^ s[4];
    s[0] = s[0] ^ s[3];
    s[3] = s[3] ^ (s[4] & s[2]);
    s[2] = s[2] ^ (s[0] & s[1]);

    s[5] = ~s[5];
    s[6] = s[6] ^ (s[5] | s[7]);
    s[7] = s[7] ^ (s[5] | s[6]);
    s[5] = s[5] ^ (s[6] & s[7]);
    for (int b = 0; b < 8; b++) begin
      y[8*b +: 8] = s[b];
    end
    return y;
  endfunction

endpackage

// ===== src/pipo_block_cipher_64_128_unit.sv =====
// PIPO-64/128 pipelined encrypt/decrypt engine with APB key registers.
`timescale 1ns / 1ps
// One block per cycle while req_stall is low, through ROUNDS + 2 register stages: an input
// register, one register stage per cipher round (key add, S-layer and rotate layer, or their
// inverses for decryption, chosen per item by cmd), and an output register that applies the
// final round key. Each stage advances on its own when the next one is empty or moving, so
// bubbles close up and the input keeps taking items while a result waits at the output;
// req_stall rises only when every stage is full and rsp_stall is high. Keys live at APB byte
// address 0 (key_low) and 8 (key_high), 64 bits each; write them only while the pipeline is
// empty.
module pipo_block_cipher_64_128_unit
  import pipo_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // request channel
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  cmd,
  input  logic [BLOCK_W-1:0]    block_in,
  // response channel
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [BLOCK_W-1:0]    block_out
);

  localparam int LAST = ROUNDS + 1;

  key_t key_low;
  key_t key_high;

  // stage 0: input register, 1..ROUNDS: round outputs, LAST: output register
  block_t st_data [LAST+1];
  logic   st_cmd  [LAST+1];
  logic   st_vld  [LAST+1];
  logic   adv     [LAST+1];

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3])
        REG_KEY_LOW:  key_low  <= pwdata;
        REG_KEY_HIGH: key_high <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_KEY_LOW:  prdata = key_low;
      REG_KEY_HIGH: prdata = key_high;
      default:      prdata = '0;
    endcase
  end

  // a stage may load when it is empty or its item moves on
  assign adv[LAST] = !st_vld[LAST] || !rsp_stall;
  for (genvar k = 0; k < LAST; k++) begin : g_adv
    assign adv[k] = !st_vld[k] || adv[k+1];
  end

  assign req_stall = !adv[0];

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld[0] <= 1'b0;
    end else if (adv[0]) begin
      st_vld[0] <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && req_valid) begin
      st_data[0] <= block_in;
      st_cmd[0]  <= cmd;
    end
  end

  // round stages
  for (genvar j = 1; j <= ROUNDS; j++) begin : g_round
    localparam rnd_t R_ENC = RND_W'(j - 1);
    localparam rnd_t R_DEC = RND_W'(ROUNDS - j + 1);

    block_t keyed;
    block_t data_next;

    always_comb begin
      if (st_cmd[j-1] == CMD_DEC) begin
        keyed     = st_data[j-1] ^ round_key(R_DEC, key_low, key_high);
        data_next = inv_sbox(rot_inv(keyed));
      end else begin
        keyed     = st_data[j-1] ^ round_key(R_ENC, key_low, key_high);
        data_next = rot_fwd(sbox_fwd(keyed));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[j] <= 1'b0;
      end else if (adv[j]) begin
        st_vld[j] <= st_vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j] && st_vld[j-1]) begin
        st_data[j] <= data_next;
        st_cmd[j]  <= st_cmd[j-1];
      end
    end
  end

  // output register: final round key
  localparam rnd_t R_FINAL = RND_W'(ROUNDS);

  block_t final_key;
  assign final_key = (st_cmd[ROUNDS] == CMD_DEC) ? round_key('0, key_low, key_high)
                                                 : round_key(R_FINAL, key_low, key_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld[LAST] <= 1'b0;
    end else if (adv[LAST]) begin
      st_vld[LAST] <= st_vld[ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[LAST] && st_vld[ROUNDS]) begin
      st_data[LAST] <= st_data[ROUNDS] ^ final_key;
      st_cmd[LAST]  <= st_cmd[ROUNDS];
    end
  end

  assign rsp_valid = st_vld[LAST];
  assign block_out = st_data[LAST];

  // the input backs up only when the output is held
  a_stall_from_out : assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (rsp_valid && rsp_stall))
    else $error("request stalled while output free");

  // an item in the last round stage holds while the output register is blocked
  a_last_hold : assert property (@(posedge clk) disable iff (rst)
    (st_vld[ROUNDS] && !adv[ROUNDS]) |=> (st_vld[ROUNDS] && $stable(st_data[ROUNDS])))
    else $error("last round stage lost an item under stall");

  // a delivered item with nothing behind it leaves the output empty
  a_drain : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && !st_vld[ROUNDS]) |=> !rsp_valid)
    else $error("output item repeated");

endmodule
